/* hw/rtl/ssc_pkg.sv */
// Shared types and constants of the servo sweep controller.
package ssc_pkg;

  localparam int unsigned AngleW   = 8;
  localparam int unsigned StepW    = 8;
  localparam int unsigned PeriodW  = 13;

  localparam logic [AngleW-1:0]  MAX_ANGLE   = AngleW'(180);
  localparam logic [PeriodW-1:0] MAX_PERIOD  = PeriodW'(5000);
  localparam logic [PeriodW-1:0] ELAPSED_MAX = {PeriodW{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_POSITION = 2'd1,
    CMD_SWEEP    = 2'd2,
    CMD_UNKNOWN  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ANGLE      = 3'd1,
    ST_LOW_BOUND  = 3'd2,
    ST_HIGH_BOUND = 3'd3,
    ST_ORDER      = 3'd4,
    ST_STEP       = 3'd5,
    ST_PERIOD     = 3'd6,
    ST_UNKNOWN    = 3'd7
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [AngleW-1:0]  angle_a;
    logic [AngleW-1:0]  angle_b;
    logic [StepW-1:0]   step_size;
    logic [PeriodW-1:0] period_ms;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [AngleW-1:0] servo_angle;
    logic              angle_written;
    status_e           status;
    logic              sweeping;
  } result_t;

endpackage

/* hw/rtl/ssc_in_stage.sv */
// Input register of the servo sweep controller.
module ssc_in_stage import ssc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  consume_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || consume_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hw/rtl/ssc_core.sv */
// Sweep state and per-beat command evaluation.
module ssc_core import ssc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic               active_q, active_d;
  logic [AngleW-1:0]  position_q, position_d;
  logic               going_up_q, going_up_d;
  logic [AngleW-1:0]  low_q, low_d;
  logic [AngleW-1:0]  high_q, high_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [PeriodW-1:0] interval_q, interval_d;
  logic [PeriodW-1:0] elapsed_q, elapsed_d;

  logic [AngleW:0]    up_sum, low_sum;
  logic [AngleW-1:0]  up_pos, step_pos;
  logic               step_up;
  logic [PeriodW-1:0] elapsed_inc;
  status_e            sweep_st;
  result_t            res;

  // One sweep step, derived from the current state
  always_comb begin
    up_sum  = {1'b0, position_q} + {1'b0, step_q};
    up_pos  = (up_sum > {1'b0, high_q}) ? high_q : up_sum[AngleW-1:0];
    low_sum = {1'b0, low_q} + {1'b0, step_q};
    if (going_up_q && (position_q < high_q)) begin
      step_pos = up_pos;
      step_up  = 1'b1;
    end else if (position_q > low_q) begin
      step_pos = ({1'b0, position_q} < low_sum) ? low_q : position_q - step_q;
      step_up  = 1'b0;
    end else begin
      // bounce off the low bound
      step_pos = up_pos;
      step_up  = 1'b1;
    end
  end

  assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;

  always_comb begin
    if (item_i.angle_a > MAX_ANGLE) begin
      sweep_st = ST_LOW_BOUND;
    end else if (item_i.angle_b > MAX_ANGLE) begin
      sweep_st = ST_HIGH_BOUND;
    end else if (item_i.angle_a >= item_i.angle_b) begin
      sweep_st = ST_ORDER;
    end else if (item_i.step_size > item_i.angle_b - item_i.angle_a) begin
      sweep_st = ST_STEP;
    end else if (item_i.period_ms > MAX_PERIOD) begin
      sweep_st = ST_PERIOD;
    end else begin
      sweep_st = ST_OK;
    end
  end

  // Next state
  always_comb begin
    active_d   = active_q;
    position_d = position_q;
    going_up_d = going_up_q;
    low_d      = low_q;
    high_d     = high_q;
    step_d     = step_q;
    interval_d = interval_q;
    elapsed_d  = elapsed_q;
    if (fire_i) begin
      case (item_i.cmd)
        CMD_TICK: begin
          if (active_q) begin
            if (elapsed_inc > interval_q) begin
              elapsed_d  = '0;
              position_d = step_pos;
              going_up_d = step_up;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        CMD_SWEEP: begin
          if (sweep_st == ST_OK) begin
            low_d      = item_i.angle_a;
            high_d     = item_i.angle_b;
            step_d     = item_i.step_size;
            interval_d = item_i.period_ms;
            position_d = item_i.angle_a;
            going_up_d = 1'b1;
            elapsed_d  = '0;
            active_d   = 1'b1;
          end
        end
        default: begin
          active_d = 1'b0;
        end
      endcase
    end
  end

  // Result of the beat
  always_comb begin
    res.valid         = fire_i;
    res.servo_angle   = '0;
    res.angle_written = 1'b0;
    res.status        = ST_OK;
    res.sweeping      = active_d;
    case (item_i.cmd)
      CMD_TICK: begin
        res.valid         = fire_i && active_q && (elapsed_inc > interval_q);
        res.servo_angle   = step_pos;
        res.angle_written = 1'b1;
      end
      CMD_POSITION: begin
        if (item_i.angle_a > MAX_ANGLE) begin
          res.status = ST_ANGLE;
        end else begin
          res.servo_angle   = item_i.angle_a;
          res.angle_written = 1'b1;
        end
      end
      CMD_SWEEP: begin
        res.status = sweep_st;
        if (sweep_st == ST_OK) begin
          res.servo_angle   = item_i.angle_a;
          res.angle_written = 1'b1;
        end
      end
      default: begin
        res.status = ST_UNKNOWN;
      end
    endcase
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      position_q <= '0;
      going_up_q <= 1'b0;
      low_q      <= '0;
      high_q     <= '0;
      step_q     <= '0;
      interval_q <= '0;
      elapsed_q  <= '0;
    end else begin
      active_q   <= active_d;
      position_q <= position_d;
      going_up_q <= going_up_d;
      low_q      <= low_d;
      high_q     <= high_d;
      step_q     <= step_d;
      interval_q <= interval_d;
      elapsed_q  <= elapsed_d;
    end
  end

endmodule

/* hw/rtl/ssc_out_stage.sv */
// Result register of the servo sweep controller.
module ssc_out_stage import ssc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  result_t result_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = can_load_o ? result_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && result_i.valid) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* hw/rtl/servo_sweep_controller.sv */
// Top level of the servo sweep controller.
// Takes one beat per clock: ticks and position, sweep or unknown commands. A beat
// is latched in the input register, evaluated combinationally against the sweep
// state, and its result, if any, lands in the output register, which presents it
// on the master side. Sustained rate is one beat per cycle; it drops only while
// the output register is full and not taken. Every position, sweep or unknown
// command yields one result; a tick yields one only when the sweep steps. No
// clearing pass is needed after reset.
module servo_sweep_controller import ssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // angle_a[7:0], angle_b[15:8], step_size[23:16], period_ms[36:24], zeros
  input  logic [39:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // servo_angle[7:0], angle_written[8], sweeping[9], zeros
  output logic [15:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]  m_axis_tuser_o
);

  item_t   in_item, cur_item;
  logic    cur_valid, can_load, fire;
  result_t core_res, out_res;

  assign in_item.cmd       = cmd_e'(s_axis_tuser_i);
  assign in_item.angle_a   = s_axis_tdata_i[7:0];
  assign in_item.angle_b   = s_axis_tdata_i[15:8];
  assign in_item.step_size = s_axis_tdata_i[23:16];
  assign in_item.period_ms = s_axis_tdata_i[36:24];

  assign fire = cur_valid && can_load;

  ssc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .consume_i  (fire),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  ssc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (cur_item),
    .result_o (core_res)
  );

  ssc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (core_res),
    .can_load_o  (can_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.sweeping, out_res.angle_written, out_res.servo_angle};
  assign m_axis_tuser_o = out_res.status;

endmodule
